### sv/isq_pkg.sv
package isq_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed field widths of the command and result items
  localparam int CMD_W  = 3;
  localparam int POS_W  = 8;
  localparam int VAL_W  = 32;
  localparam int CNT_W  = 9;
  localparam int STAT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_INSERT     = 3'd2,
    CMD_REMOVE     = 3'd3,
    CMD_POP_FRONT  = 3'd4,
    CMD_POP_BACK   = 3'd5,
    CMD_READ       = 3'd6,
    CMD_CLEAR      = 3'd7
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value_in;
  } cmd_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] value_out;
    logic [CNT_W-1:0] occupancy;
    status_t          status;
  } res_item_t;

  // broadcast to every cell: open a slot at pos, or close the slot at pos
  typedef struct packed {
    logic             add;
    logic             take;
    logic [CNT_W-1:0] pos;
  } cell_ctl_t;

endpackage

### sv/isq_stream_if.sv
interface isq_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/isq_cell.sv
module isq_cell #(
  parameter int DATA_WIDTH = isq_pkg::DATA_WIDTH_DEF,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  isq_pkg::cell_ctl_t    ctl,
  input  logic [DATA_WIDTH-1:0] new_data,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data_q
);
  import isq_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [DATA_WIDTH-1:0] data_r;

  // slot at pos takes the new word, cells above it move up;
  // on a take, the slot at pos and everything above move down
  always_ff @(posedge clk) begin
    if (ctl.add && (ctl.pos == MY_IDX)) begin
      data_r <= new_data;
    end else if (ctl.add && (ctl.pos < MY_IDX)) begin
      data_r <= left_data;
    end else if (ctl.take && (ctl.pos <= MY_IDX)) begin
      data_r <= right_data;
    end
  end

  assign data_q = data_r;

endmodule

### sv/indexed_sequence_store_core.sv
// Channel   Dir   Payload                                  Transfer when
// in_ch     in    cmd[3], position[8], value_in[32]        in_ch.valid & in_ch.ready
// out_ch    out   value_out[32], occupancy[9], status[2]   out_ch.valid & out_ch.ready
//
// One command per cycle; its result is presented the cycle after the transfer.
// The whole row of cells shifts together, so the rate is set only by the
// output register: a new command is taken whenever that register is empty or
// is being drained in the same cycle.
// Reset (rst_n low, synchronous) empties the store, drops any held result and keeps
// in_ch.ready low; cell contents are not cleared, entries above the count are never read.
module indexed_sequence_store_core #(
  parameter int CAPACITY   = isq_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = isq_pkg::DATA_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  isq_stream_if.sink   in_ch,
  isq_stream_if.source out_ch
);
  import isq_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  res_item_t        out_res_r, res_nxt;

  logic accept;
  // no transfer in while reset is held
  assign in_ch.ready = rst_n && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  // ---------------------------------------------------------------------------
  // Row of cells
  // ---------------------------------------------------------------------------
  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
  logic [DATA_WIDTH-1:0] new_word;
  logic [63:0]           in_ext;
  cell_ctl_t             ctl;

  // value_in masked / extended to the storage width
  assign in_ext   = 64'(in_ch.data.value_in);
  assign new_word = in_ext[DATA_WIDTH-1:0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_q[i+1];
    end

    isq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .new_data   (new_word),
      .left_data  (left_w),
      .right_data (right_w),
      .data_q     (cell_q[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Command decode
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]      pos_ext;
  logic                  full, empty;
  logic                  add_ok, take_ok, rd_ok;
  logic [CNT_W-1:0]      op_pos;
  status_t               st;
  logic                  clear_cmd;
  logic [DATA_WIDTH-1:0] rd_word;
  logic [63:0]           rd_ext;

  assign pos_ext = CNT_W'(in_ch.data.position);
  assign full    = (count_r >= CAP_CNT);
  assign empty   = (count_r == '0);

  always_comb begin
    add_ok    = 1'b0;
    take_ok   = 1'b0;
    rd_ok     = 1'b0;
    clear_cmd = 1'b0;
    op_pos    = '0;
    st        = ST_OK;
    case (in_ch.data.cmd)
      CMD_PUSH_FRONT: begin
        if (full) st = ST_FULL;
        else add_ok = 1'b1;
      end
      CMD_PUSH_BACK: begin
        op_pos = count_r;
        if (full) st = ST_FULL;
        else add_ok = 1'b1;
      end
      CMD_INSERT: begin
        // range check comes before the full check
        op_pos = pos_ext;
        if (pos_ext > count_r) st = ST_RANGE;
        else if (full) st = ST_FULL;
        else add_ok = 1'b1;
      end
      CMD_REMOVE: begin
        op_pos = pos_ext;
        if (pos_ext >= count_r) st = ST_RANGE;
        else take_ok = 1'b1;
      end
      CMD_POP_FRONT: begin
        if (empty) st = ST_RANGE;
        else take_ok = 1'b1;
      end
      CMD_POP_BACK: begin
        op_pos = count_r - CNT_W'(1);
        if (empty) st = ST_RANGE;
        else take_ok = 1'b1;
      end
      CMD_READ: begin
        op_pos = pos_ext;
        if (pos_ext >= count_r) st = ST_RANGE;
        else rd_ok = 1'b1;
      end
      CMD_CLEAR: begin
        clear_cmd = 1'b1;
      end
      default: begin
        st = ST_RANGE;
      end
    endcase
  end

  // cells only move on an accepted, successful add or take
  always_comb begin
    ctl.add  = accept && add_ok;
    ctl.take = accept && take_ok;
    ctl.pos  = op_pos;
  end

  // single read port: op_pos is in range whenever the word is used
  assign rd_word = cell_q[op_pos[IDX_W-1:0]];
  assign rd_ext  = (take_ok || rd_ok) ? 64'(rd_word) : 64'd0;

  always_comb begin
    count_nxt = count_r;
    if (clear_cmd) count_nxt = '0;
    else if (add_ok) count_nxt = count_r + CNT_W'(1);
    else if (take_ok) count_nxt = count_r - CNT_W'(1);
  end

  always_comb begin
    res_nxt.value_out = rd_ext[VAL_W-1:0];
    res_nxt.occupancy = count_nxt;
    res_nxt.status    = st;
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded with each transfer in
  always_ff @(posedge clk) begin
    if (accept) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_res_r;

endmodule

### sv/isq_checker.sv
module isq_checker #(
  parameter int CAPACITY = isq_pkg::CAPACITY_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [isq_pkg::CMD_W-1:0]    in_cmd,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [isq_pkg::VAL_W-1:0]    out_value,
  input logic [isq_pkg::CNT_W-1:0]    out_occupancy,
  input logic [isq_pkg::STAT_W-1:0]   out_status
);
  import isq_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value)
      && $stable(out_occupancy) && $stable(out_status))
    else $error("result changed while stalled");

  // a clear empties the store and never fails
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_cmd == CMD_CLEAR) |=> out_valid && (out_occupancy == '0)
      && (out_status == ST_OK))
    else $error("clear did not empty the store");

  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_occupancy <= CNT_W'(CAPACITY)))
    else $error("occupancy above capacity");

  // only adds can report full
  a_full_on_add: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_cmd != CMD_PUSH_FRONT) && (in_cmd != CMD_PUSH_BACK)
      && (in_cmd != CMD_INSERT) |=> (out_status != ST_FULL))
    else $error("full status on a non-add command");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_value == '0))
    else $error("refused command returned data");

endmodule

bind indexed_sequence_store_core isq_checker #(
  .CAPACITY (CAPACITY)
) u_isq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_cmd        (in_ch.data.cmd),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_value     (out_ch.data.value_out),
  .out_occupancy (out_ch.data.occupancy),
  .out_status    (out_ch.data.status)
);

### bench/tb_indexed_sequence_store_core.sv
module tb_indexed_sequence_store_core;
  import isq_pkg::*;

  localparam int STORE_DEPTH = CAPACITY_DEF;
  localparam int DIR_N       = 24;
  localparam int TOTAL_ITEMS = 800;
  // final stretch runs with both sides streaming, no gaps
  localparam int CALM_ITEMS  = 150;
  // long output hold-off, so the result register backs up into the input
  localparam int PRESSURE_AT = 300;
  localparam int HOLD_CYCLES = 120;
  localparam int DRAIN_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_MAX = 10;

  typedef enum int {FILL_UP, DRAIN_DOWN, MIXED} phase_mode_t;

  // one row of the directed table; typed rows carry their own expected result
  typedef struct packed {
    cmd_item_t item;
    logic      typed;
    res_item_t res;
  } dir_row_t;

  logic clk;
  logic rst_n;

  isq_stream_if #(.payload_t(cmd_item_t)) in_if ();
  isq_stream_if #(.payload_t(res_item_t)) out_if ();

  indexed_sequence_store_core #(
    .CAPACITY  (STORE_DEPTH),
    .DATA_WIDTH(DATA_WIDTH_DEF)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  // shadow copy of the store, advanced once per accepted command
  logic [VAL_W-1:0] shadow_words [STORE_DEPTH];
  int               shadow_count;

  res_item_t pending_results [$];
  int        mismatch_count;
  int        sent_count;
  bit        calm;
  bit        stall_done;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow store
  // ---------------------------------------------------------------------------

  // open a slot at pos; range is checked before the full check
  function automatic status_t shadow_insert(int pos, logic [VAL_W-1:0] word);
    if (pos > shadow_count) return ST_RANGE;
    if (shadow_count >= STORE_DEPTH) return ST_FULL;
    for (int i = shadow_count; i > pos; i--) shadow_words[i] = shadow_words[i-1];
    shadow_words[pos] = word;
    shadow_count++;
    return ST_OK;
  endfunction

  function automatic status_t shadow_take(int pos, output logic [VAL_W-1:0] word);
    word = '0;
    if (pos >= shadow_count) return ST_RANGE;
    word = shadow_words[pos];
    for (int i = pos; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
    shadow_count--;
    return ST_OK;
  endfunction

  function automatic res_item_t apply_store_cmd(cmd_item_t c);
    res_item_t        r;
    logic [VAL_W-1:0] word;
    int               pos;
    r    = '0;
    word = '0;
    pos  = int'(c.position);
    case (c.cmd)
      CMD_PUSH_FRONT: r.status = shadow_insert(0, c.value_in);
      CMD_PUSH_BACK:  r.status = shadow_insert(shadow_count, c.value_in);
      CMD_INSERT:     r.status = shadow_insert(pos, c.value_in);
      CMD_REMOVE:     r.status = shadow_take(pos, word);
      CMD_POP_FRONT:  r.status = shadow_take(0, word);
      CMD_POP_BACK: begin
        if (shadow_count == 0) r.status = ST_RANGE;
        else r.status = shadow_take(shadow_count - 1, word);
      end
      CMD_READ: begin
        if (pos >= shadow_count) r.status = ST_RANGE;
        else word = shadow_words[pos];
      end
      default: begin
        shadow_count = 0;
        r.status     = ST_OK;
      end
    endcase
    r.value_out = word;
    r.occupancy = CNT_W'(shadow_count);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic dir_row_t dir_entry(cmd_t cmd, int pos, logic [VAL_W-1:0] val,
                                         logic typed, logic [VAL_W-1:0] vout, int occ,
                                         status_t st);
    dir_row_t d;
    d.item.cmd      = cmd;
    d.item.position = POS_W'(pos);
    d.item.value_in = val;
    d.typed         = typed;
    d.res.value_out = vout;
    d.res.occupancy = CNT_W'(occ);
    d.res.status    = st;
    return d;
  endfunction

  // well-formed commands most of the time, with a share of wild positions
  function automatic cmd_item_t pick_cmd(phase_mode_t mode);
    cmd_item_t c;
    int        roll;
    int        add_pct;
    int        take_pct;
    int        clear_pct;
    c    = '0;
    roll = $urandom_range(0, 99);
    case (mode)
      FILL_UP:    begin add_pct = 82; take_pct = 92; clear_pct = 0; end
      DRAIN_DOWN: begin add_pct = 12; take_pct = 88; clear_pct = 0; end
      default:    begin add_pct = 40; take_pct = 75; clear_pct = 4; end
    endcase
    if (roll < add_pct) c.cmd = cmd_t'($urandom_range(CMD_PUSH_FRONT, CMD_INSERT));
    else if (roll < take_pct) c.cmd = cmd_t'($urandom_range(CMD_REMOVE, CMD_POP_BACK));
    else if (roll < 100 - clear_pct) c.cmd = CMD_READ;
    else c.cmd = CMD_CLEAR;

    if ($urandom_range(0, 4) == 0) c.position = POS_W'($urandom_range(0, 255));
    else if (c.cmd == CMD_INSERT) c.position = POS_W'($urandom_range(0, shadow_count));
    else if (shadow_count > 0) c.position = POS_W'($urandom_range(0, shadow_count - 1));
    else c.position = '0;

    case ($urandom_range(0, 9))
      0:       c.value_in = '0;
      1:       c.value_in = '1;
      default: c.value_in = $urandom;
    endcase
    return c;
  endfunction

  // offer one command, hold it until the transfer, then log its prediction
  task automatic drive_cmd(input cmd_item_t item, input logic typed, input res_item_t typed_res);
    res_item_t predicted;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= item;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predicted = apply_store_cmd(item);
    pending_results.push_back(typed ? typed_res : predicted);
    sent_count++;
    calm = (sent_count >= TOTAL_ITEMS - CALM_ITEMS);
  endtask

  initial begin : stim
    dir_row_t    steps [DIR_N];
    phase_mode_t mode;
    int          burst;
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.data     <= '0;
    out_if.ready   <= 1'b0;
    shadow_count   = 0;
    mismatch_count = 0;
    sent_count     = 0;
    calm           = 1'b0;
    stall_done     = 1'b0;
    for (int i = 0; i < STORE_DEPTH; i++) shadow_words[i] = '0;

    // empty-store refusals, inserts at and past the count, window extremes, clear
    steps = '{
      dir_entry(CMD_POP_FRONT,  0,   32'h0,        1, 32'h0,        0, ST_RANGE),
      dir_entry(CMD_POP_BACK,   0,   32'h0,        1, 32'h0,        0, ST_RANGE),
      dir_entry(CMD_REMOVE,     0,   32'h0,        1, 32'h0,        0, ST_RANGE),
      dir_entry(CMD_READ,       0,   32'h0,        1, 32'h0,        0, ST_RANGE),
      dir_entry(CMD_INSERT,     1,   32'h1234_5678, 1, 32'h0,       0, ST_RANGE),
      dir_entry(CMD_INSERT,     255, 32'hFFFF_FFFF, 1, 32'h0,       0, ST_RANGE),
      dir_entry(CMD_INSERT,     0,   32'hFFFF_FFFF, 1, 32'h0,       1, ST_OK),
      dir_entry(CMD_PUSH_FRONT, 255, 32'h0,        1, 32'h0,        2, ST_OK),
      dir_entry(CMD_PUSH_BACK,  0,   32'hA5A5_A5A5, 1, 32'h0,       3, ST_OK),
      dir_entry(CMD_READ,       0,   32'h0,        0, 32'h0,        0, ST_OK),
      dir_entry(CMD_READ,       1,   32'hFFFF_FFFF, 0, 32'h0,       0, ST_OK),
      dir_entry(CMD_READ,       3,   32'h0,        1, 32'h0,        3, ST_RANGE),
      dir_entry(CMD_READ,       255, 32'h0,        1, 32'h0,        3, ST_RANGE),
      dir_entry(CMD_INSERT,     3,   32'h5A5A_5A5A, 0, 32'h0,       0, ST_OK),
      dir_entry(CMD_INSERT,     1,   32'h0000_0001, 0, 32'h0,       0, ST_OK),
      dir_entry(CMD_REMOVE,     255, 32'hFFFF_FFFF, 1, 32'h0,       5, ST_RANGE),
      dir_entry(CMD_REMOVE,     2,   32'h0,        0, 32'h0,        0, ST_OK),
      dir_entry(CMD_POP_FRONT,  0,   32'h0,        0, 32'h0,        0, ST_OK),
      dir_entry(CMD_POP_BACK,   0,   32'h0,        0, 32'h0,        0, ST_OK),
      dir_entry(CMD_READ,       0,   32'h0,        0, 32'h0,        0, ST_OK),
      dir_entry(CMD_CLEAR,      0,   32'h0,        1, 32'h0,        0, ST_OK),
      dir_entry(CMD_CLEAR,      255, 32'hFFFF_FFFF, 1, 32'h0,       0, ST_OK),
      dir_entry(CMD_PUSH_BACK,  0,   32'h8000_0000, 1, 32'h0,       1, ST_OK),
      dir_entry(CMD_REMOVE,     0,   32'h0,        1, 32'h8000_0000, 0, ST_OK)
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (steps[i]) drive_cmd(steps[i].item, steps[i].typed, steps[i].res);

    // episodes that fill to full, drain past empty, or wander
    while (sent_count < TOTAL_ITEMS) begin
      mode  = phase_mode_t'($urandom_range(FILL_UP, MIXED));
      burst = $urandom_range(15, 45);
      repeat (burst)
        if (sent_count < TOTAL_ITEMS) drive_cmd(pick_cmd(mode), 1'b0, '0);
    end
    in_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // result side: random hold-off bursts, one long stall, none at the end
  initial begin : drain_side
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!stall_done && sent_count >= PRESSURE_AT) begin
        stall_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_if.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 7);
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : result_check
    res_item_t want;
    res_item_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected transfer: value_out=%h occupancy=%0d status=%0d",
                   got.value_out, got.occupancy, got.status);
      end else begin
        want = pending_results.pop_front();
        if (got.value_out !== want.value_out || got.occupancy !== want.occupancy ||
            got.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("result mismatch: value_out exp %h got %h, occupancy exp %0d got %0d, status exp %0d got %0d",
                     want.value_out, got.value_out, want.occupancy, got.occupancy,
                     want.status, got.status);
        end
      end
    end
  end

  // any transfer on either channel resets the count
  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
